@@ rtl/core/jac3d_pkg.sv @@
// ---------------------------------------------------------------------------
// Jacobi 3D sweep package
// Shared sizes, register indexes, read selects and the controller/datapath
// command and status types.
// ---------------------------------------------------------------------------
package jac3d_pkg;

  // Largest grid the buffers are built for.
  localparam int MAX_X = 64;
  localparam int MAX_Y = 64;
  localparam int MAX_Z = 1024;

  // Potential window holds two planes plus one point; the delay line one plane plus one.
  localparam int WIN_DEPTH = 2 * MAX_X * MAX_Y + 1;
  localparam int DLY_DEPTH = MAX_X * MAX_Y + 1;

  // Widths derived from the grid limits.
  localparam int NXW = $clog2(MAX_X + 1);
  localparam int NYW = $clog2(MAX_Y + 1);
  localparam int NZW = $clog2(MAX_Z + 1);
  localparam int XW  = $clog2(MAX_X);
  localparam int YW  = $clog2(MAX_Y);
  localparam int ZW  = $clog2(MAX_Z);
  localparam int PLW = $clog2(MAX_X * MAX_Y + 1);
  localparam int WPW = $clog2(WIN_DEPTH);
  localparam int DPW = $clog2(DLY_DEPTH);

  // Fixed field widths of the interface.
  localparam int PXW = 6;
  localparam int PYW = 6;
  localparam int PZW = 10;
  localparam int ACC_W = 63;

  // Arithmetic widths.
  localparam int SUM_W = 35;
  localparam int NUM_W = 50;
  localparam int DIV_BITS = 8;
  localparam int DIV_STEPS = 7;
  localparam int DIV_W = DIV_BITS * DIV_STEPS;
  localparam int STW = 3;
  localparam int READS = 5;

  // Configuration register indexes.
  localparam logic [1:0] CFG_SIZE_X = 2'd0;
  localparam logic [1:0] CFG_SIZE_Y = 2'd1;
  localparam logic [1:0] CFG_SIZE_Z = 2'd2;
  localparam logic [1:0] CFG_CELL   = 2'd3;

  // Neighbour read selects, issued in this order.
  localparam logic [STW-1:0] RD_XP = 3'd0;
  localparam logic [STW-1:0] RD_XM = 3'd1;
  localparam logic [STW-1:0] RD_YP = 3'd2;
  localparam logic [STW-1:0] RD_YM = 3'd3;
  localparam logic [STW-1:0] RD_ZM = 3'd4;

  typedef struct packed {
    logic           accept;
    logic           rd_issue;
    logic [STW-1:0] rd_sel;
    logic           add_en;
    logic           mul_en;
    logic           num_load;
    logic           div_step;
    logic           sat_en;
    logic           sq_en;
    logic           out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic interior;
  } dp_status_t;

endpackage

@@ rtl/core/jac3d_dp.sv @@
// ---------------------------------------------------------------------------
// Jacobi 3D sweep datapath
// Configuration registers, raster position, potential window and delay
// memories, neighbour sum, divide by six, error square and accumulator.
// ---------------------------------------------------------------------------
module jac3d_dp (
  input  logic                       clk,
  input  logic                       rst,
  input  jac3d_pkg::dp_cmd_t         cmd,
  output jac3d_pkg::dp_status_t      status,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_index,
  input  logic [31:0]                cfg_data,
  input  logic signed [31:0]         old_potential,
  input  logic signed [31:0]         source_term,
  input  logic signed [31:0]         reference_value,
  output logic signed [31:0]         new_potential,
  output logic [jac3d_pkg::PXW-1:0]  point_x,
  output logic [jac3d_pkg::PYW-1:0]  point_y,
  output logic [jac3d_pkg::PZW-1:0]  point_z,
  output logic [jac3d_pkg::ACC_W-1:0] error_sum,
  output logic                       sweep_end
);
  import jac3d_pkg::*;

  localparam int WKW = WPW + 1;
  localparam int DKW = DPW + 1;
  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  logic [6:0]  size_x;
  logic [6:0]  size_y;
  logic [10:0] size_z;
  logic [31:0] cell_product;
  logic [NXW-1:0] nx;
  logic [NYW-1:0] ny;
  logic [NZW-1:0] nz;
  logic [PLW-1:0] plane;
  logic restart;

  logic [XW-1:0]  pos_x;
  logic [YW-1:0]  pos_y;
  logic [ZW-1:0]  pos_z;
  logic [WPW-1:0] win_ptr;
  logic [DPW-1:0] dly_ptr;
  logic x_end, y_end, z_end, interior_now, last_now;

  logic [XW-1:0]  pt_x;
  logic [YW-1:0]  pt_y;
  logic [ZW-1:0]  pt_z;
  logic           pt_last;
  logic [WPW-1:0] base_w;
  logic [DPW-1:0] base_d;

  logic [31:0] win_mem [WIN_DEPTH];
  logic [63:0] dly_mem [DLY_DEPTH];
  logic signed [31:0] win_rdata;
  logic [63:0] dly_rdata;
  logic [WKW-1:0] win_back;
  logic [WPW-1:0] win_raddr;
  logic [DPW-1:0] dly_raddr;

  logic signed [SUM_W-1:0] sum;
  logic signed [63:0] prod;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [31:0] ref_hold;
  logic signed [NUM_W-1:0] num;
  logic [NUM_W-1:0] num_mag;
  logic num_neg;
  logic [DIV_W-1:0] div_word;
  logic [2:0]       div_rem;
  logic [DIV_W-1:0] div_word_next;
  logic [2:0]       div_rem_next;
  logic signed [31:0] q_sat;
  logic signed [32:0] err;
  logic [32:0] err_abs;
  logic signed [31:0] q_r;
  logic [31:0] err_mag;
  logic [63:0] sq;
  logic [ACC_W+1:0] acc_sum;
  logic [ACC_W-1:0] acc_new;
  logic [ACC_W-1:0] acc;

  // Configuration registers; a size write restarts the sweep.
  assign restart = cfg_we && (cfg_index != CFG_CELL);

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x       <= 7'd64;
      size_y       <= 7'd64;
      size_z       <= 11'd64;
      cell_product <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIZE_X: size_x <= cfg_data[6:0];
        CFG_SIZE_Y: size_y <= cfg_data[6:0];
        CFG_SIZE_Z: size_z <= cfg_data[10:0];
        CFG_CELL:   cell_product <= cfg_data;
        default:    cell_product <= cell_product;
      endcase
    end
  end

  // Sizes in use, clamped to the range the buffers support.
  always_comb begin
    if (size_x < 7'd3) nx = NXW'(3);
    else if (int'(size_x) > MAX_X) nx = NXW'(MAX_X);
    else nx = NXW'(size_x);
    if (size_y < 7'd3) ny = NYW'(3);
    else if (int'(size_y) > MAX_Y) ny = NYW'(MAX_Y);
    else ny = NYW'(size_y);
    if (size_z < 11'd3) nz = NZW'(3);
    else if (int'(size_z) > MAX_Z) nz = NZW'(MAX_Z);
    else nz = NZW'(size_z);
  end

  assign plane = PLW'(nx) * PLW'(ny);

  // Classification of the point at the current raster position.
  always_comb begin
    x_end = (NXW'(pos_x) == nx - NXW'(1));
    y_end = (NYW'(pos_y) == ny - NYW'(1));
    z_end = (NZW'(pos_z) == nz - NZW'(1));
    interior_now = (pos_z >= ZW'(2)) && (pos_x != '0) && (pos_y != '0)
                   && (NXW'(pos_x) <= nx - NXW'(2)) && (NYW'(pos_y) <= ny - NYW'(2));
    last_now = (NXW'(pos_x) == nx - NXW'(2)) && (NYW'(pos_y) == ny - NYW'(2)) && z_end;
  end

  assign status.interior = interior_now;

  // Raster position and ring pointers.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      pos_x   <= '0;
      pos_y   <= '0;
      pos_z   <= '0;
      win_ptr <= '0;
      dly_ptr <= '0;
    end else if (cmd.accept) begin
      if (x_end && y_end && z_end) begin
        pos_x   <= '0;
        pos_y   <= '0;
        pos_z   <= '0;
        win_ptr <= '0;
        dly_ptr <= '0;
      end else begin
        if (x_end) begin
          pos_x <= '0;
          if (y_end) begin
            pos_y <= '0;
            pos_z <= pos_z + ZW'(1);
          end else begin
            pos_y <= pos_y + YW'(1);
          end
        end else begin
          pos_x <= pos_x + XW'(1);
        end
        win_ptr <= (win_ptr == WPW'(WIN_DEPTH - 1)) ? '0 : win_ptr + WPW'(1);
        dly_ptr <= (dly_ptr == DPW'(DLY_DEPTH - 1)) ? '0 : dly_ptr + DPW'(1);
      end
    end
  end

  // Details of the accepted point, held while its update is worked out.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      pt_x    <= pos_x;
      pt_y    <= pos_y;
      pt_z    <= pos_z - ZW'(1);
      pt_last <= last_now;
      base_w  <= win_ptr;
      base_d  <= dly_ptr;
    end
  end

  // Distance back from the newest point to each neighbour of the centre point.
  always_comb begin
    case (cmd.rd_sel)
      RD_XP:   win_back = WKW'(plane) - WKW'(1);
      RD_XM:   win_back = WKW'(plane) + WKW'(1);
      RD_YP:   win_back = WKW'(plane) - WKW'(nx);
      RD_YM:   win_back = WKW'(plane) + WKW'(nx);
      RD_ZM:   win_back = WKW'(plane) + WKW'(plane);
      default: win_back = WKW'(plane) + WKW'(plane);
    endcase
    if (WKW'(base_w) >= win_back) win_raddr = WPW'(WKW'(base_w) - win_back);
    else win_raddr = WPW'(WKW'(base_w) + WKW'(WIN_DEPTH) - win_back);
    if (DKW'(base_d) >= DKW'(plane)) dly_raddr = DPW'(DKW'(base_d) - DKW'(plane));
    else dly_raddr = DPW'(DKW'(base_d) + DKW'(DLY_DEPTH) - DKW'(plane));
  end

  // Potential window: written on accept, one registered read a cycle.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      win_mem[win_ptr] <= old_potential;
    end
    if (cmd.rd_issue) begin
      win_rdata <= win_mem[win_raddr];
    end
  end

  // Source and reference delay line, read once per update.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      dly_mem[dly_ptr] <= {source_term, reference_value};
    end
    if (cmd.rd_issue && (cmd.rd_sel == RD_XP)) begin
      dly_rdata <= dly_mem[dly_raddr];
    end
  end

  // Neighbour sum and source product.
  assign mul_a = 33'(signed'(dly_rdata[63:32]));
  assign mul_b = signed'({1'b0, cell_product});

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      sum <= SUM_W'(old_potential);
    end else if (cmd.add_en) begin
      sum <= sum + SUM_W'(win_rdata);
    end
    if (cmd.mul_en) begin
      prod     <= mul_a * mul_b;
      ref_hold <= signed'(dly_rdata[31:0]);
    end
  end

  // Numerator with the product floored to Q16.16, then its magnitude.
  always_comb begin
    num     = NUM_W'(sum) - NUM_W'(prod >>> 16);
    num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
  end

  // Restoring division by six, DIV_BITS quotient bits per division step.
  always_comb begin
    logic [3:0] trial;
    div_rem_next  = div_rem;
    div_word_next = div_word;
    for (int i = 0; i < DIV_BITS; i++) begin
      trial = {div_rem_next, div_word_next[DIV_W-1]};
      div_word_next = {div_word_next[DIV_W-2:0], 1'b0};
      if (trial >= 4'd6) begin
        div_rem_next = 3'(trial - 4'd6);
        div_word_next[0] = 1'b1;
      end else begin
        div_rem_next = trial[2:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.num_load) begin
      num_neg  <= num[NUM_W-1];
      div_word <= DIV_W'(num_mag + NUM_W'(3));
      div_rem  <= '0;
    end else if (cmd.div_step) begin
      div_word <= div_word_next;
      div_rem  <= div_rem_next;
    end
  end

  // Signed quotient saturated to 32 bits, and its error against the reference.
  always_comb begin
    if (!num_neg && (div_word[DIV_W-1:31] != '0)) begin
      q_sat = 32'sh7FFF_FFFF;
    end else if (num_neg && ((div_word[DIV_W-1:32] != '0)
                 || (div_word[31] && (div_word[30:0] != '0)))) begin
      q_sat = 32'sh8000_0000;
    end else if (num_neg) begin
      q_sat = -signed'(div_word[31:0]);
    end else begin
      q_sat = signed'(div_word[31:0]);
    end
    err     = 33'(q_sat) - 33'(ref_hold);
    err_abs = err[32] ? 33'(-err) : 33'(err);
  end

  always_ff @(posedge clk) begin
    if (cmd.sat_en) begin
      q_r     <= q_sat;
      err_mag <= err_abs[31:0];
    end
    if (cmd.sq_en) begin
      sq <= err_mag * err_mag;
    end
  end

  // Saturating error accumulator; it clears after the last point of a sweep.
  always_comb begin
    acc_sum = {2'b00, acc} + {1'b0, sq};
    acc_new = (acc_sum > (ACC_W+2)'(ACC_MAX)) ? ACC_MAX : acc_sum[ACC_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      acc <= '0;
    end else if (cmd.out_load) begin
      acc <= pt_last ? '0 : acc_new;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      new_potential <= q_r;
      point_x       <= PXW'(pt_x);
      point_y       <= PYW'(pt_y);
      point_z       <= PZW'(pt_z);
      error_sum     <= acc_new;
      sweep_end     <= pt_last;
    end
  end

endmodule

@@ rtl/core/jac3d_ctrl.sv @@
// ---------------------------------------------------------------------------
// Jacobi 3D sweep controller
// Sequences neighbour reads, division steps and the result hand-off, and
// owns both handshakes.
// ---------------------------------------------------------------------------
module jac3d_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  jac3d_pkg::dp_status_t status,
  output jac3d_pkg::dp_cmd_t    cmd
);
  import jac3d_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_READ   = 3'd1;
  localparam logic [2:0] ST_TAIL   = 3'd2;
  localparam logic [2:0] ST_NUM    = 3'd3;
  localparam logic [2:0] ST_DIV    = 3'd4;
  localparam logic [2:0] ST_SAT    = 3'd5;
  localparam logic [2:0] ST_SQ     = 3'd6;
  localparam logic [2:0] ST_COMMIT = 3'd7;

  logic [2:0]     state;
  logic [2:0]     state_next;
  logic [STW-1:0] step;
  logic [STW-1:0] step_next;
  logic           out_free;

  assign in_ready = (state == ST_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and datapath commands.
  always_comb begin
    cmd        = '0;
    cmd.rd_sel = step;
    state_next = state;
    step_next  = step;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          step_next  = '0;
          if (status.interior) state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_issue = 1'b1;
        cmd.add_en   = (step != '0);
        if (step == STW'(READS - 1)) begin
          step_next  = '0;
          state_next = ST_TAIL;
        end else begin
          step_next = step + STW'(1);
        end
      end
      ST_TAIL: begin
        cmd.add_en = 1'b1;
        cmd.mul_en = 1'b1;
        state_next = ST_NUM;
      end
      ST_NUM: begin
        cmd.num_load = 1'b1;
        step_next    = '0;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (step == STW'(DIV_STEPS - 1)) begin
          step_next  = '0;
          state_next = ST_SAT;
        end else begin
          step_next = step + STW'(1);
        end
      end
      ST_SAT: begin
        cmd.sat_en = 1'b1;
        state_next = ST_SQ;
      end
      ST_SQ: begin
        cmd.sq_en  = 1'b1;
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  // Result valid flag for the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // A result is never loaded over one that has not been taken.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> out_free)
    else $error("result register overwritten");

  // An interior point always starts the neighbour reads.
  a_interior_reads: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && status.interior) |=> (state == ST_READ))
    else $error("interior point did not start reads");

  // The read step never runs past the last neighbour.
  a_read_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ) |-> (step < STW'(READS)))
    else $error("read step out of range");

  // The division step never runs past the last division step.
  a_div_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (step < STW'(DIV_STEPS)))
    else $error("division step out of range");

endmodule

@@ rtl/core/jacobi_3d_seven_point_sweep_core.sv @@
// ---------------------------------------------------------------------------
// Jacobi 3D seven-point sweep core
// Streams grid points in raster order and emits the Jacobi update and the
// running squared error for every interior point.
// ---------------------------------------------------------------------------
// Input channel (in_valid/in_ready): one grid point per transaction, x
// fastest, then y, then z, carrying old potential, source and reference.
// Output channel (out_valid/out_ready): one transaction per interior point,
// with its new potential, indices, running error sum and the sweep end mark.
// Boundary points are taken without leaving the idle state and give no result.
// The update of an interior point is worked out in these steps:
// five neighbour reads through the single read port of the potential window,
// a product stage, seven divide-by-six steps of eight bits each, saturation,
// squaring and the accumulator. The next point is taken once that result
// sits in the output register; no new point is taken while one is in work.
// If the receiver stalls, the finished result waits in the output register
// and the block holds its next result back until that one is taken.
// Reset (rst, synchronous) restores the default sizes and cell product and
// starts a new sweep; a write to a size register also starts a new sweep.
// There is no clearing pass: window entries are always written before read.
// ---------------------------------------------------------------------------
module jacobi_3d_seven_point_sweep_core (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [31:0]           old_potential,
  input  logic signed [31:0]           source_term,
  input  logic signed [31:0]           reference_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [31:0]           new_potential,
  output logic [jac3d_pkg::PXW-1:0]    point_x,
  output logic [jac3d_pkg::PYW-1:0]    point_y,
  output logic [jac3d_pkg::PZW-1:0]    point_z,
  output logic [jac3d_pkg::ACC_W-1:0]  error_sum,
  output logic                         sweep_end,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [31:0]                  cfg_data
);
  import jac3d_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  // Sequencing and handshakes.
  jac3d_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // Storage and arithmetic.
  jac3d_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .old_potential   (old_potential),
    .source_term     (source_term),
    .reference_value (reference_value),
    .new_potential   (new_potential),
    .point_x         (point_x),
    .point_y         (point_y),
    .point_z         (point_z),
    .error_sum       (error_sum),
    .sweep_end       (sweep_end)
  );

endmodule
